>>> sv/owo_pkg.sv
package owo_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned TableLen    = 24;
  localparam int unsigned StepW       = $clog2(TableLen);

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] PiQ29      = 34'sd1686629713;
  localparam logic signed [33:0] HalfPiQ29  = 34'sd843314857;

  localparam logic [0:0] RegRadius = 1'b0;
  localparam logic [0:0] RegYawGain = 1'b1;

  typedef struct packed {
    logic signed [15:0] heading;
    logic signed [23:0] speed_front_left;
    logic signed [23:0] speed_front_right;
    logic signed [23:0] speed_rear_right;
    logic signed [23:0] speed_rear_left;
    logic        [15:0] time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] turn_rate;
    logic signed [47:0] position_x;
    logic signed [47:0] position_y;
    logic signed [31:0] heading_total;
  } out_item_t;

  // datapath commands
  typedef struct packed {
    logic load;      // capture item, set up CORDIC
    logic rot;       // one CORDIC step
    logic mac;       // one multiply step
    logic [3:0] idx; // multiply step select
    logic [StepW-1:0] step;
  } cmd_t;

  function automatic logic signed [33:0] atan_q29(input logic [StepW-1:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0: r = 34'sd421657428;
      5'd1: r = 34'sd248918915;
      5'd2: r = 34'sd131521918;
      5'd3: r = 34'sd66762579;
      5'd4: r = 34'sd33510843;
      5'd5: r = 34'sd16771758;
      5'd6: r = 34'sd8387925;
      5'd7: r = 34'sd4194219;
      5'd8: r = 34'sd2097141;
      5'd9: r = 34'sd1048575;
      default: r = 34'sd1 <<< (5'd29 - i);
    endcase
    return r;
  endfunction

endpackage

>>> sv/owo_datapath.sv
module owo_datapath (
  input  logic             clk_i,
  input  owo_pkg::cmd_t    cmd_i,
  input  owo_pkg::in_item_t item_i,
  input  logic [15:0]      radius_i,
  input  logic [15:0]      gain_i,
  input  logic             rst_ni,
  output owo_pkg::out_item_t res_o
);

  logic signed [33:0] x_q, y_q, z_q;
  logic flip_q;
  owo_pkg::in_item_t it_q;
  logic signed [33:0] z0;
  logic signed [33:0] dx, dy, at;

  logic signed [18:0] cps_q, cms_q;
  logic signed [47:0] sx_q, sy_q;
  logic signed [27:0] wsum_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] vx_q, vy_q, wr_q;
  logic signed [47:0] px_q, py_q;
  logic signed [31:0] hd_q;

  logic signed [33:0] xf, yf;
  logic signed [34:0] csum, cdif;
  logic signed [18:0] cps, cms;
  logic signed [43:0] p1a, p1b;

  assign z0 = 34'(item_i.heading) <<< 16;
  assign at = owo_pkg::atan_q29(cmd_i.step);
  assign dx = y_q >>> cmd_i.step;
  assign dy = x_q >>> cmd_i.step;
  assign xf = flip_q ? -x_q : x_q;
  assign yf = flip_q ? -y_q : y_q;
  assign csum = 35'(xf) + 35'(yf) + 35'sd32768;
  assign cdif = 35'(xf) - 35'(yf) + 35'sd32768;
  assign cps = 19'(csum >>> 16);
  assign cms = 19'(cdif >>> 16);

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // CORDIC rotation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q <= item_i;
      x_q <= owo_pkg::CordicGain;
      y_q <= '0;
      if (z0 > owo_pkg::HalfPiQ29) begin
        z_q <= z0 - owo_pkg::PiQ29; flip_q <= 1'b1;
      end else if (z0 < -owo_pkg::HalfPiQ29) begin
        z_q <= z0 + owo_pkg::PiQ29; flip_q <= 1'b1;
      end else begin
        z_q <= z0; flip_q <= 1'b0;
      end
    end else if (cmd_i.rot) begin
      if (!z_q[33]) begin
        x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
      end
    end
  end

  // at most one multiply per step: partial products, then scaling to vx, vy and turn rate
  always_comb begin
    p1a = 44'(cps_q) * 44'(it_q.speed_front_left);
    p1b = '0;
    case (cmd_i.idx)
      4'd1: p1a = 44'(cps_q) * 44'(it_q.speed_front_left);
      4'd2: p1a = 44'(cms_q) * 44'(it_q.speed_front_right);
      4'd3: p1a = 44'(cps_q) * 44'(it_q.speed_rear_right);
      4'd4: p1a = 44'(cms_q) * 44'(it_q.speed_rear_left);
      4'd5: p1b = 44'(cms_q) * 44'(it_q.speed_front_left);
      4'd6: p1b = 44'(cps_q) * 44'(it_q.speed_front_right);
      4'd7: p1b = 44'(cms_q) * 44'(it_q.speed_rear_right);
      4'd8: p1b = 44'(cps_q) * 44'(it_q.speed_rear_left);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      wsum_q <= 28'(item_i.speed_front_left) + 28'(item_i.speed_front_right)
              + 28'(item_i.speed_rear_right) + 28'(item_i.speed_rear_left);
    end
    if (cmd_i.mac) begin
      unique case (cmd_i.idx)
        4'd0: begin
          cps_q <= cps; cms_q <= cms; sx_q <= '0; sy_q <= '0;
        end
        4'd1: sx_q <= sx_q + 48'(p1a);
        4'd2: sx_q <= sx_q + 48'(p1a);
        4'd3: sx_q <= sx_q - 48'(p1a);
        4'd4: sx_q <= sx_q - 48'(p1a);
        4'd5: sy_q <= sy_q - 48'(p1b);
        4'd6: sy_q <= sy_q + 48'(p1b);
        4'd7: sy_q <= sy_q + 48'(p1b);
        4'd8: sy_q <= sy_q - 48'(p1b);
        // vx: sx*R split into two products
        4'd9: prod_q <= 64'($signed(sx_q[47:16])) * 64'({1'b0, radius_i});
        4'd10: begin
          prod_q <= (prod_q <<< 16) + 64'({1'b0, sx_q[15:0]}) * 64'({1'b0, radius_i});
          sx_q <= sy_q;
        end
        4'd11: begin
          vx_q <= sat((prod_q + 64'sd33554432) >>> 26);
          prod_q <= 64'($signed(sx_q[47:16])) * 64'({1'b0, radius_i});
        end
        4'd12: prod_q <= (prod_q <<< 16)
                         + 64'({1'b0, sx_q[15:0]}) * 64'({1'b0, radius_i});
        4'd13: begin
          vy_q <= sat((prod_q + 64'sd33554432) >>> 26);
          prod_q <= 64'(wsum_q) * 64'({1'b0, radius_i});
        end
        4'd14: prod_q <= 64'($signed(prod_q[43:0])) * 64'({1'b0, gain_i});
        default: begin
          wr_q <= sat((prod_q + 64'sd524288) >>> 20);
        end
      endcase
    end
  end

  // integration, in the controller's integrate state (idx 1, no other command)
  logic signed [47:0] ix, iy;
  logic signed [31:0] ih;
  assign ix = 48'((64'(vx_q) * 64'({1'b0, it_q.time_step}) + 64'sd32768) >>> 16);
  assign iy = 48'((64'(vy_q) * 64'({1'b0, it_q.time_step}) + 64'sd32768) >>> 16);
  assign ih = 32'((64'(wr_q) * 64'({1'b0, it_q.time_step}) + 64'sd32768) >>> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0; py_q <= '0; hd_q <= '0;
    end else if (cmd_i.rot == 1'b0 && cmd_i.mac == 1'b0 && cmd_i.load == 1'b0
                 && cmd_i.idx == 4'd1) begin
      px_q <= px_q + ix; py_q <= py_q + iy; hd_q <= hd_q + ih;
    end
  end

  assign res_o.velocity_x = vx_q;
  assign res_o.velocity_y = vy_q;
  assign res_o.turn_rate = wr_q;
  assign res_o.position_x = px_q;
  assign res_o.position_y = py_q;
  assign res_o.heading_total = hd_q;

endmodule

>>> sv/owo_ctrl.sv
module owo_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output owo_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ROT  = 5'b00010,
    S_MAC  = 5'b00100,
    S_INT  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [owo_pkg::StepW-1:0] cnt_q, cnt_d;

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_o = '0;
    cmd_o.step = cnt_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1; state_d = S_ROT; cnt_d = '0;
      end
      S_ROT: begin
        cmd_o.rot = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == owo_pkg::StepW'(owo_pkg::CordicSteps - 1)) begin
          state_d = S_MAC; cnt_d = '0;
        end
      end
      S_MAC: begin
        cmd_o.mac = 1'b1;
        cmd_o.idx = cnt_q[3:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == owo_pkg::StepW'(15)) state_d = S_INT;
      end
      S_INT: begin
        cmd_o.idx = 4'd1;
        state_d = S_OUT;
      end
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o) else $error("accept while busy");
  a_int_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INT |=> state_q == S_OUT) else $error("sequence slip");

endmodule

>>> sv/omni_wheel_odometry_integrator.sv
// channel | direction | handshake        | payload
// in      | input     | in_valid/in_stall | in_item_t
// out     | output    | out_valid/out_stall | out_item_t
// cfg     | input     | cfg_valid/cfg_ready | index, data
// An item runs through the CORDIC iteration, then the multiply sequence
// and the integration step before its result is offered.
// Reset clears the position and heading accumulators and the configuration registers to their defaults.
// A stalled result holds; the next item is taken once it leaves.
module omni_wheel_odometry_integrator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  owo_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output owo_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  logic [15:0] radius_q, gain_q;
  owo_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd8192;
      gain_q <= 16'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        owo_pkg::RegRadius: radius_q <= cfg_data_i;
        owo_pkg::RegYawGain: gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  owo_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd)
  );

  owo_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .item_i(in_data_i),
    .radius_i(radius_q), .gain_i(gain_q), .res_o(out_data_o)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NumSteps = owo_pkg::CordicSteps;
  localparam int unsigned IdleLimit = 20000;
  localparam logic signed [63:0] GainQ30 = 64'sd652032874;
  localparam logic signed [63:0] PiQ29L = 64'sd1686629713;
  localparam logic signed [63:0] HalfPiQ29L = 64'sd843314857;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  owo_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  owo_pkg::out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i = owo_pkg::RegRadius;
  logic [15:0] cfg_data_i = '0;

  bit quiet_mode = 1'b0;
  int unsigned idle_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  omni_wheel_odometry_integrator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Odometry predictor plus queue of pending pose results
  class odometry_board;
    logic [15:0] radius;
    logic [15:0] yaw_gain;
    logic [47:0] dist_x;
    logic [47:0] dist_y;
    logic [31:0] yaw_total;
    owo_pkg::out_item_t pending_poses[$];
    int unsigned mismatches;

    function new();
      radius = 16'd8192;
      yaw_gain = 16'd256;
      dist_x = '0;
      dist_y = '0;
      yaw_total = '0;
      mismatches = 0;
    endfunction

    function logic signed [63:0] floor_shr(logic signed [63:0] v, int unsigned s);
      return v >>> s;
    endfunction

    function logic signed [63:0] round_shr(logic signed [63:0] v, int unsigned s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function logic signed [63:0] clip32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function logic signed [63:0] arctan(int unsigned i);
      case (i)
        0: return 64'sd421657428;
        1: return 64'sd248918915;
        2: return 64'sd131521918;
        3: return 64'sd66762579;
        4: return 64'sd33510843;
        5: return 64'sd16771758;
        6: return 64'sd8387925;
        7: return 64'sd4194219;
        8: return 64'sd2097141;
        9: return 64'sd1048575;
        default: return 64'sd1 <<< (29 - i);
      endcase
    endfunction

    // Note an accepted item and queue the pose it produces
    function void note_item(owo_pkg::in_item_t it);
      logic signed [63:0] ang, cx, sy, dx, dy, cps, cms, w0, w1, w2, w3;
      logic signed [63:0] sumx, sumy, vx, vy, wr, t;
      bit flip;
      owo_pkg::out_item_t res;
      ang = 64'(it.heading) * 65536;
      cx = GainQ30;
      sy = 0;
      flip = 0;
      if (ang > HalfPiQ29L) begin
        ang -= PiQ29L;
        flip = 1;
      end else if (ang < -HalfPiQ29L) begin
        ang += PiQ29L;
        flip = 1;
      end
      for (int unsigned i = 0; i < NumSteps; i++) begin
        dx = floor_shr(sy, i);
        dy = floor_shr(cx, i);
        if (ang >= 0) begin
          cx -= dx;
          sy += dy;
          ang -= arctan(i);
        end else begin
          cx += dx;
          sy -= dy;
          ang += arctan(i);
        end
      end
      if (flip) begin
        cx = -cx;
        sy = -sy;
      end
      cps = round_shr(cx + sy, 16);
      cms = round_shr(cx - sy, 16);
      w0 = 64'(it.speed_front_left);
      w1 = 64'(it.speed_front_right);
      w2 = 64'(it.speed_rear_right);
      w3 = 64'(it.speed_rear_left);
      t = 64'($unsigned(it.time_step));
      sumx = cps * w0 + cms * w1 - cps * w2 - cms * w3;
      sumy = -cms * w0 + cps * w1 + cms * w2 - cps * w3;
      vx = clip32(round_shr(sumx * 64'(radius), 26));
      vy = clip32(round_shr(sumy * 64'(radius), 26));
      wr = clip32(round_shr((w0 + w1 + w2 + w3) * 64'(radius) * 64'(yaw_gain), 20));
      dist_x = dist_x + 48'(round_shr(vx * t, 16));
      dist_y = dist_y + 48'(round_shr(vy * t, 16));
      yaw_total = yaw_total + 32'(round_shr(wr * t, 16));
      res.velocity_x = 32'(vx);
      res.velocity_y = 32'(vy);
      res.turn_rate = 32'(wr);
      res.position_x = dist_x;
      res.position_y = dist_y;
      res.heading_total = yaw_total;
      pending_poses.push_back(res);
    endfunction

    // Compare a delivered pose with the oldest pending one
    function void check_pose(owo_pkg::out_item_t got);
      owo_pkg::out_item_t exp_pose;
      if (pending_poses.size() == 0) begin
        $error("unexpected result transaction");
        mismatches++;
        return;
      end
      exp_pose = pending_poses.pop_front();
      if (got.velocity_x !== exp_pose.velocity_x) begin
        $error("velocity_x exp %0d got %0d", exp_pose.velocity_x, got.velocity_x);
        mismatches++;
      end
      if (got.velocity_y !== exp_pose.velocity_y) begin
        $error("velocity_y exp %0d got %0d", exp_pose.velocity_y, got.velocity_y);
        mismatches++;
      end
      if (got.turn_rate !== exp_pose.turn_rate) begin
        $error("turn_rate exp %0d got %0d", exp_pose.turn_rate, got.turn_rate);
        mismatches++;
      end
      if (got.position_x !== exp_pose.position_x) begin
        $error("position_x exp %0d got %0d", exp_pose.position_x, got.position_x);
        mismatches++;
      end
      if (got.position_y !== exp_pose.position_y) begin
        $error("position_y exp %0d got %0d", exp_pose.position_y, got.position_y);
        mismatches++;
      end
      if (got.heading_total !== exp_pose.heading_total) begin
        $error("heading_total exp %0d got %0d", exp_pose.heading_total,
               got.heading_total);
        mismatches++;
      end
    endfunction
  endclass

  odometry_board board = new();

  // Monitor: accepted inputs feed the predictor, accepted results are checked
  always @(posedge clk_i) begin : monitor
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        board.note_item(in_data_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        board.check_pose(out_data_o);
        moved = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == owo_pkg::RegRadius) board.radius = cfg_data_i;
        else board.yaw_gain = cfg_data_i;
        moved = 1'b1;
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  // Result-side stall
  always @(posedge clk_i) begin
    out_stall_i <= quiet_mode ? 1'b0 : ($urandom_range(99) < 11);
  end

  task automatic send_item(owo_pkg::in_item_t it);
    while (!quiet_mode && $urandom_range(99) < 11) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (board.pending_poses.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic owo_pkg::in_item_t rand_item();
    owo_pkg::in_item_t it;
    it.heading = 16'($signed($urandom_range(51472)) - 25736);
    if ($urandom_range(9) == 0) it.heading = 16'($urandom);
    it.speed_front_left = 24'($urandom);
    it.speed_front_right = 24'($urandom);
    it.speed_rear_right = 24'($urandom);
    it.speed_rear_left = 24'($urandom);
    if ($urandom_range(1)) begin
      it.speed_front_left = 24'($signed(24'($urandom)) >>> $urandom_range(20));
      it.speed_front_right = 24'($signed(24'($urandom)) >>> $urandom_range(20));
    end
    it.time_step = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
    return it;
  endfunction

  function automatic owo_pkg::in_item_t make_item(int hd, int w0, int w1, int w2, int w3,
                                                  int dt);
    owo_pkg::in_item_t it;
    it.heading = 16'(hd);
    it.speed_front_left = 24'(w0);
    it.speed_front_right = 24'(w1);
    it.speed_rear_right = 24'(w2);
    it.speed_rear_left = 24'(w3);
    it.time_step = 16'(dt);
    return it;
  endfunction

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (idle_cycles > IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [15:0] radius_set[4];
    logic [15:0] gain_set[4];
    radius_set = '{16'hFFFF, 16'd0, 16'd1, 16'd40000};
    gain_set = '{16'hFFFF, 16'd1, 16'd0, 16'd3000};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: defaults, extreme headings and speeds, zero time step
    send_item(make_item(0, 4096, 4096, 4096, 4096, 65535));
    send_item(make_item(25736, 8388607, -8388608, 8388607, -8388608, 65535));
    send_item(make_item(-25736, -8388608, 8388607, -8388608, 8388607, 65535));
    send_item(make_item(32767, 8388607, 8388607, 8388607, 8388607, 1));
    send_item(make_item(-32768, -8388608, -8388608, -8388608, -8388608, 1));
    send_item(make_item(12868, 1000, -2000, 3000, -4000, 0));
    send_item(make_item(12869, 123456, 654321, -1, 0, 32768));
    send_item(make_item(-12868, -1, -1, -1, -1, 65535));
    send_item(make_item(-12869, 0, 0, 0, 0, 65535));
    drain();
    write_reg(owo_pkg::RegRadius, 16'hFFFF);
    write_reg(owo_pkg::RegYawGain, 16'hFFFF);
    send_item(make_item(6000, 8388607, 8388607, 8388607, 8388607, 65535));
    send_item(make_item(-6000, -8388608, -8388608, -8388608, -8388608, 65535));
    send_item(make_item(20000, 8388607, 0, -8388608, 0, 65535));

    // Random phases across register settings; one phase runs without idling
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      if (ph < 4) begin
        write_reg(owo_pkg::RegRadius, radius_set[ph]);
        write_reg(owo_pkg::RegYawGain, gain_set[ph]);
      end else begin
        write_reg(owo_pkg::RegRadius, 16'($urandom));
        write_reg(owo_pkg::RegYawGain, 16'($urandom));
      end
      quiet_mode = (ph == 2);
      for (int n = 0; n < 100; n++) begin
        if (n == 50) drain();
        send_item(rand_item());
      end
    end
    quiet_mode = 1'b0;

    drain();
    if (board.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
